FILE: hw/rtl/bwm_pkg.sv
// Shared types and fixed constants for the banned word masker.
// No dependencies; used by every module of the block.
package bwm_pkg;

    localparam int CHAR_W    = 8;
    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;

    localparam logic [CHAR_W-1:0] MASK_CHAR = 8'h2A;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              line_end;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } t_out_item;

    typedef struct packed {
        logic draining;
        logic empty;
        logic emit;
    } t_back_status;

endpackage

FILE: hw/rtl/banned_word_masker.sv
// Top level of the banned word masker: word registers, front queue, back end.
// Depends on bwm_pkg, bwm_front and bwm_back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One character per cycle in steady state while the output is not stalled; the
// back end tests all words at the oldest window position in the same cycle it
// emits that character. An item with line_end drains the window: one output per
// cycle while the output is not stalled; the queue is not read during the drain.
// Reset is synchronous and clears word registers, queue and window fill.
// Output stall holds the output register; the 4-entry queue accepts until full.
module banned_word_masker #(
    parameter int NUM_WORDS    = 8,
    parameter int MAX_WORD_LEN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bwm_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bwm_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [bwm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bwm_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int IW = bwm_pkg::CFG_IDX_W;

    logic [NUM_WORDS-1:0][bwm_pkg::WORD_W-1:0] r_word;
    logic                  q_valid;
    bwm_pkg::t_in_item     q_data;
    logic                  q_pop;
    bwm_pkg::t_back_status st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (i_cfg_we && (i_cfg_idx == IW'(k))) begin
                    r_word[k] <= i_cfg_data;
                end
            end
        end
    end

    bwm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_data   (q_data),
        .i_q_pop    (q_pop)
    );

    bwm_back #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_words     (r_word),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_status    (st)
    );

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.draining |-> !st.empty)
        else $error("draining with an empty window");

    a_no_pop_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.draining |-> !q_pop)
        else $error("queue read during drain");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.emit |=> o_out_valid)
        else $error("emitted item not presented");

endmodule

FILE: hw/rtl/bwm_front.sv
// Front end of the masker: accepts items and holds them in a short queue.
// Depends on bwm_pkg for the item type and the queue depth.
module bwm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bwm_pkg::t_in_item i_in_data,
    output logic              o_q_valid,
    output bwm_pkg::t_in_item o_q_data,
    input  logic              i_q_pop
);

    localparam int QAW = bwm_pkg::QAW;

    bwm_pkg::t_in_item r_mem [bwm_pkg::QDEPTH];
    logic [QAW-1:0]    r_wptr;
    logic [QAW-1:0]    r_rptr;
    logic [QAW:0]      r_count;
    logic              push;
    logic              pop;

    assign o_in_stall = (r_count == (QAW+1)'(bwm_pkg::QDEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_data   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/bwm_back.sv
// Back end of the masker: character window, word match and mask, drain, output register.
// Depends on bwm_pkg for item types, the mask character and the status struct.
module bwm_back #(
    parameter int NUM_WORDS    = 8,
    parameter int MAX_WORD_LEN = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [NUM_WORDS-1:0][bwm_pkg::WORD_W-1:0] i_words,
    input  logic                                     i_q_valid,
    input  bwm_pkg::t_in_item                        i_q_data,
    output logic                                     o_q_pop,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output bwm_pkg::t_out_item                       o_out_data,
    output bwm_pkg::t_back_status                    o_status
);

    localparam int FW = $clog2(MAX_WORD_LEN + 1);
    localparam int CW = bwm_pkg::CHAR_W;

    logic [CW-1:0] r_win [MAX_WORD_LEN];
    logic [FW-1:0] r_fill;
    logic          r_draining;
    logic          r_ov;
    bwm_pkg::t_out_item r_out;

    logic [CW-1:0] wa      [MAX_WORD_LEN];
    logic [CW-1:0] src_win [MAX_WORD_LEN];
    logic [CW-1:0] tst     [MAX_WORD_LEN];
    logic [CW-1:0] sh      [MAX_WORD_LEN];
    logic [FW-1:0] len     [NUM_WORDS];
    logic [FW-1:0] fa;
    logic [FW-1:0] src_fill;
    logic          need;
    logic          out_ready;
    logic          pop;
    logic          emit;
    logic          end_flag;

    // Word lengths: count of bytes before the first zero byte.
    always_comb begin
        for (int k = 0; k < NUM_WORDS; k++) begin
            len[k] = FW'(MAX_WORD_LEN);
            for (int i = MAX_WORD_LEN - 1; i >= 0; i--) begin
                if (i_words[k][CW*i +: CW] == '0) begin
                    len[k] = FW'(i);
                end
            end
        end
    end

    always_comb begin
        fa = r_fill + 1'b1;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            wa[i] = (r_fill == FW'(i)) ? i_q_data.text_char : r_win[i];
        end
        need      = i_q_data.line_end || (fa == FW'(MAX_WORD_LEN));
        out_ready = !r_ov || !i_out_stall;
        pop       = i_q_valid && !r_draining && (!need || out_ready);
        emit      = r_draining ? out_ready : (pop && need);
        end_flag  = r_draining || i_q_data.line_end;
        src_fill  = r_draining ? r_fill : fa;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            src_win[i] = r_draining ? r_win[i] : wa[i];
        end
    end

    // Test each word in order at the oldest position; later words see earlier masks.
    always_comb begin
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            tst[i] = src_win[i];
        end
        for (int k = 0; k < NUM_WORDS; k++) begin
            hit = (len[k] != '0) && (len[k] <= src_fill);
            for (int i = 0; i < MAX_WORD_LEN; i++) begin
                if ((FW'(i) < len[k]) && (tst[i] != i_words[k][CW*i +: CW])) begin
                    hit = 1'b0;
                end
            end
            for (int i = 0; i < MAX_WORD_LEN; i++) begin
                if (hit && (FW'(i) < len[k])) begin
                    tst[i] = bwm_pkg::MASK_CHAR;
                end
            end
        end
        for (int i = 0; i < MAX_WORD_LEN - 1; i++) begin
            sh[i] = tst[i+1];
        end
        sh[MAX_WORD_LEN-1] = tst[MAX_WORD_LEN-1];
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_win              <= sh;
            r_out.out_char     <= tst[0];
            r_out.out_last     <= end_flag && (src_fill == FW'(1));
        end else if (pop) begin
            r_win <= wa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_draining <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (emit) begin
                r_fill     <= src_fill - 1'b1;
                r_draining <= end_flag && (src_fill > FW'(1));
                r_ov       <= 1'b1;
            end else begin
                if (pop) begin
                    r_fill <= fa;
                end
                if (!i_out_stall) begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

    assign o_q_pop           = pop;
    assign o_out_valid       = r_ov;
    assign o_out_data        = r_out;
    assign o_status.draining = r_draining;
    assign o_status.empty    = (r_fill == '0);
    assign o_status.emit     = emit;

endmodule
